// ===== rtl/mean_distance_classifier_unit_assert.svh =====
// assertion macros for the mean distance classifier
`ifndef MEAN_DISTANCE_CLASSIFIER_UNIT_ASSERT_SVH
`define MEAN_DISTANCE_CLASSIFIER_UNIT_ASSERT_SVH

// implication checked on every rising clock edge out of reset
`define MDC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mdc_pkg.sv =====
// ---------------------------------------------------------------------------
// mdc_pkg
// types and constants of the mean distance classifier
// ---------------------------------------------------------------------------
package mdc_pkg;

  localparam int unsigned MaxSamplesDef = 256;
  localparam int unsigned NumAttrDef    = 9;
  localparam int unsigned NumClassesDef = 7;

  localparam int unsigned AttrW  = 24;
  localparam int unsigned ClassW = 3;
  localparam int unsigned MeanW  = 26;
  localparam int unsigned SqW    = 52;
  localparam int unsigned RootW  = 26;
  localparam int unsigned SumW   = 40;
  localparam int unsigned OpW    = 2;
  localparam int unsigned InW    = 224;
  localparam int unsigned OutW   = 32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_SQRT,
    ST_CLS,
    ST_DIV,
    ST_CMP,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/mean_distance_classifier_unit.sv =====
// sequence: clear and ignored beats finish in idle; a load writes one attribute per
// ST_WRITE step; a query walks ST_RD, ST_MUL, ST_ACC per attribute on the single
// memory port, then 26 root steps and ST_CLS per sample, then a divider pass and a
// compare per class before ST_OUT (an empty store goes straight to ST_OUT)
// throughput: one beat at a time; s_axis_tready low while in work or a result waits
// reset: asynchronous, active low, empties the store; memories are not cleared
// ---------------------------------------------------------------------------
// mean_distance_classifier_unit
// stores labelled samples and classifies queries by smallest mean distance
// ---------------------------------------------------------------------------
module mean_distance_classifier_unit #(
  parameter int unsigned MAX_SAMPLES    = mdc_pkg::MaxSamplesDef,
  parameter int unsigned NUM_ATTRIBUTES = mdc_pkg::NumAttrDef,
  parameter int unsigned NUM_CLASSES    = mdc_pkg::NumClassesDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // attr_0..attr_8 [215:0], sample_label[218:216], zero fill
  input  logic [mdc_pkg::InW-1:0] s_axis_tdata,
  // operation[1:0]
  input  logic [mdc_pkg::OpW-1:0] s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // predicted_class[2:0], mean_distance[28:3], zero fill
  output logic [mdc_pkg::OutW-1:0] m_axis_tdata
);
  import mdc_pkg::*;

  localparam int unsigned IdxW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AIdxW = (NUM_ATTRIBUTES > 1) ? $clog2(NUM_ATTRIBUTES) : 1;
  localparam int unsigned MemD  = MAX_SAMPLES * NUM_ATTRIBUTES;
  localparam int unsigned MAdrW = (MemD > 1) ? $clog2(MemD) : 1;
  localparam int unsigned KW    = $clog2(NUM_CLASSES + 1);
  localparam int unsigned AccW  = RootW + CntW;
  localparam int unsigned LblOff = 9 * AttrW;

  logic [AttrW-1:0]  attr_mem [MemD];
  logic [ClassW-1:0] class_mem [MAX_SAMPLES];

  state_e state_q, state_d;
  logic [CntW-1:0]   count_q;
  logic [IdxW-1:0]   idx_q;
  logic [AIdxW-1:0]  aidx_q;
  logic [MAdrW-1:0]  madr_q;
  logic [AttrW-1:0]  query_q [NUM_ATTRIBUTES];
  logic [ClassW-1:0] label_q;
  logic [AttrW-1:0]  rd_q;
  logic [ClassW-1:0] cls_rd_q;
  logic [AttrW-1:0]  diff_q;
  logic [SqW-1:0]    sq_q;
  logic [SqW-1:0]    rem_q;
  logic [RootW-1:0]  root_q;
  logic [4:0]        step_q;
  logic [AccW-1:0]   tot_q [NUM_CLASSES];
  logic [CntW-1:0]   ccnt_q [NUM_CLASSES];
  logic [KW-1:0]     k_q;
  logic [AccW-1:0]   dquo_q;
  logic [CntW:0]     drem_q;
  logic [5:0]        dstep_q;
  logic [ClassW-1:0] best_cls_q;
  logic [MeanW-1:0]  best_q;
  logic              out_valid_q;
  logic [OutW-1:0]   out_q;

  logic in_acc;
  logic [1:0] op_in;
  logic [ClassW-1:0] lbl_in;
  logic label_ok;

  assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign op_in  = s_axis_tuser;
  assign lbl_in = s_axis_tdata[LblOff +: ClassW];
  assign label_ok = (lbl_in != '0) && ({1'b0, lbl_in} <= (ClassW+1)'(NUM_CLASSES));
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // one root bit per step: trial = (root << 2 | 1) vs remainder window
  logic [SqW-1:0] sq_trial_rem;
  logic [RootW+1:0] sq_trial;
  logic [RootW+2:0] sq_win;
  assign sq_win   = {rem_q[RootW:0], sq_q[SqW-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};
  assign sq_trial_rem = '0;

  // divider trial: restoring, one quotient bit per step
  logic [CntW:0] div_win;
  logic [CntW-1:0] div_cnt;
  assign div_cnt = ccnt_q[k_q[KW-1:0] - KW'(1)];
  assign div_win = {drem_q[CntW-1:0], dquo_q[AccW-1]};

  logic [MeanW-1:0] mean_now;
  assign mean_now = dquo_q[MeanW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_e'(op_in))
            OP_LOAD:  if (count_q < CntW'(MAX_SAMPLES) && label_ok) state_d = ST_WRITE;
            OP_QUERY: state_d = (count_q == '0) ? ST_OUT : ST_RD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: if (aidx_q == AIdxW'(NUM_ATTRIBUTES - 1)) state_d = ST_IDLE;
      ST_RD:    state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = (aidx_q == AIdxW'(NUM_ATTRIBUTES - 1)) ? ST_SQRT : ST_RD;
      ST_SQRT:  if (step_q == 5'(RootW - 1)) state_d = ST_CLS;
      ST_CLS:   state_d = ({1'b0, idx_q} == CntW'(count_q - 1'b1)) ? ST_DIV : ST_RD;
      ST_DIV:   if (dstep_q == 6'(AccW)) state_d = ST_CMP;
      ST_CMP:   state_d = (k_q == KW'(NUM_CLASSES)) ? ST_OUT : ST_DIV;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      if (state_q == ST_OUT) out_valid_q <= 1'b1;
      if (in_acc && op_e'(op_in) == OP_CLEAR) count_q <= '0;
      if (state_q == ST_WRITE && state_d == ST_IDLE) count_q <= count_q + 1'b1;
    end
  end

  // datapath and memories
  always_ff @(posedge clk_i) begin
    rd_q     <= attr_mem[madr_q];
    cls_rd_q <= class_mem[idx_q];
    if (state_q == ST_WRITE) begin
      attr_mem[madr_q] <= query_q[aidx_q];
      if (aidx_q == '0) class_mem[count_q[IdxW-1:0]] <= label_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          for (int a = 0; a < NUM_ATTRIBUTES; a++)
            query_q[a] <= s_axis_tdata[a*AttrW +: AttrW];
          label_q <= lbl_in;
          aidx_q  <= '0;
          idx_q   <= '0;
          madr_q  <= (op_e'(op_in) == OP_LOAD)
                     ? MAdrW'(count_q * NUM_ATTRIBUTES) : '0;
          sq_q    <= '0;
          for (int c = 0; c < NUM_CLASSES; c++) begin
            tot_q[c]  <= '0;
            ccnt_q[c] <= '0;
          end
          best_cls_q <= '0;
          best_q     <= '0;
        end
      end
      ST_WRITE: begin
        aidx_q <= aidx_q + 1'b1;
        madr_q <= madr_q + 1'b1;
      end
      ST_RD: ;
      ST_MUL: begin
        diff_q <= (rd_q >= query_q[aidx_q]) ? rd_q - query_q[aidx_q]
                                           : query_q[aidx_q] - rd_q;
      end
      ST_ACC: begin
        sq_q   <= sq_q + SqW'(diff_q * diff_q);
        madr_q <= madr_q + 1'b1;
        if (aidx_q == AIdxW'(NUM_ATTRIBUTES - 1)) begin
          aidx_q <= '0;
          rem_q  <= '0;
          root_q <= '0;
          step_q <= '0;
        end else begin
          aidx_q <= aidx_q + 1'b1;
        end
      end
      ST_SQRT: begin
        sq_q   <= {sq_q[SqW-3:0], 2'b00};
        step_q <= step_q + 1'b1;
        if ({{(SqW-RootW-3){1'b0}}, sq_win} >= {{(SqW-RootW-2){1'b0}}, sq_trial}) begin
          rem_q  <= SqW'(sq_win - (RootW+3)'(sq_trial)) | sq_trial_rem;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= SqW'(sq_win);
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      ST_CLS: begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if ({1'b0, cls_rd_q} == (ClassW+1)'(c + 1)) begin
            tot_q[c]  <= tot_q[c] + AccW'(root_q);
            ccnt_q[c] <= ccnt_q[c] + 1'b1;
          end
        end
        sq_q  <= '0;
        idx_q <= idx_q + 1'b1;
        k_q   <= KW'(1);
        dquo_q  <= ({1'b0, cls_rd_q} == (ClassW+1)'(1)) ? tot_q[0] + AccW'(root_q)
                                                        : tot_q[0];
        drem_q  <= '0;
        dstep_q <= '0;
      end
      ST_DIV: begin
        if (dstep_q != 6'(AccW)) begin
          dstep_q <= dstep_q + 1'b1;
          if (div_win >= {1'b0, div_cnt}) begin
            drem_q <= div_win - {1'b0, div_cnt};
            dquo_q <= {dquo_q[AccW-2:0], 1'b1};
          end else begin
            drem_q <= div_win;
            dquo_q <= {dquo_q[AccW-2:0], 1'b0};
          end
        end
      end
      ST_CMP: begin
        if (div_cnt != '0 && (best_cls_q == '0 || mean_now < best_q)) begin
          best_cls_q <= ClassW'(k_q);
          best_q     <= mean_now;
        end
        if (k_q != KW'(NUM_CLASSES)) begin
          dquo_q <= tot_q[k_q];
          k_q    <= k_q + 1'b1;
        end
        drem_q  <= '0;
        dstep_q <= '0;
      end
      ST_OUT: begin
        out_q <= {{(OutW-ClassW-MeanW){1'b0}}, best_q, best_cls_q};
      end
      default: ;
    endcase
    if (state_q == ST_SQRT && state_d == ST_CLS) madr_q <= madr_q;
  end

  `include "mean_distance_classifier_unit_assert.svh"

  `MDC_ASSERT_IMPL(a_busy_not_ready, (state_q != ST_IDLE), !s_axis_tready)
  `MDC_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(MAX_SAMPLES))
  `MDC_ASSERT_NEXT(a_out_follows, (state_q == ST_OUT), m_axis_tvalid)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives clear, load and query beats into the classifier and checks every
// classification against a mean-distance predictor kept in step with the store
// ---------------------------------------------------------------------------
module testbench;
  import mdc_pkg::*;

  localparam int unsigned MaxS  = 256;
  localparam int unsigned NAttr = 9;
  localparam int unsigned NCls  = 7;
  localparam longint CycleLimit = 64'd3000000;

  typedef struct packed {
    logic [ClassW-1:0] cls;
    logic [MeanW-1:0]  mean;
  } verdict_t;

  class verdict_board;
    logic [AttrW-1:0]  store_attr [MaxS][NAttr];
    logic [ClassW-1:0] store_cls [MaxS];
    int unsigned       count;
    verdict_t          pending [$];
    int                errors;
    int                n_checked;

    function void note_beat(logic [OpW-1:0] u, logic [InW-1:0] d);
      op_e               op;
      logic [AttrW-1:0]  q [NAttr];
      logic [ClassW-1:0] lab;
      logic [63:0]       acc, dd, tot [NCls+1], mean, best_mean;
      int unsigned       cnt [NCls+1];
      int unsigned       best;
      verdict_t          v;
      op  = op_e'(u);
      lab = d[218:216];
      for (int a = 0; a < NAttr; a++) q[a] = d[a*AttrW +: AttrW];
      case (op)
        OP_CLEAR: count = 0;
        OP_LOAD: begin
          if (count < MaxS && lab >= 1 && lab <= NCls) begin
            for (int a = 0; a < NAttr; a++) store_attr[count][a] = q[a];
            store_cls[count] = lab;
            count++;
          end
        end
        OP_QUERY: begin
          for (int c = 0; c <= NCls; c++) begin
            tot[c] = 0;
            cnt[c] = 0;
          end
          for (int i = 0; i < count; i++) begin
            acc = 0;
            for (int a = 0; a < NAttr; a++) begin
              dd = (store_attr[i][a] >= q[a]) ? store_attr[i][a] - q[a]
                                              : q[a] - store_attr[i][a];
              acc += dd * dd;
            end
            tot[store_cls[i]] += int_root(acc);
            cnt[store_cls[i]]++;
          end
          best = 0;
          best_mean = 0;
          for (int c = 1; c <= NCls; c++) begin
            if (cnt[c] != 0) begin
              mean = tot[c] / cnt[c];
              if (best == 0 || mean < best_mean) begin
                best = c;
                best_mean = mean;
              end
            end
          end
          v.cls  = best[ClassW-1:0];
          v.mean = best_mean[MeanW-1:0];
          pending.insert(pending.size(), v);
        end
        default: ;
      endcase
    endfunction

    function logic [63:0] int_root(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void check_result(logic [OutW-1:0] d);
      verdict_t w;
      n_checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, d);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (d[2:0] !== w.cls) begin
        $display("%0t: class mismatch, expected %0d, got %0d", $time, w.cls, d[2:0]);
        errors++;
      end
      if (d[28:3] !== w.mean) begin
        $display("%0t: mean mismatch, expected %h, got %h", $time, w.mean, d[28:3]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic [OpW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;

  verdict_board board = new();
  longint cycles = 0;
  bit     hold_off = 1'b0;
  bit     stim_done = 1'b0;
  int     n_loads = 0, n_queries = 0;

  always #6 clk_i = ~clk_i;

  mean_distance_classifier_unit dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // sample both sides at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) board.note_beat(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // receiver: random stalls, long hold-off on request
  initial begin
    int w;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready = 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_off = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      m_axis_tready = (w == 0);
      if (w != 0) begin
        repeat (w - 1) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  function automatic logic [AttrW-1:0] rand_attr(bit near);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return near ? AttrW'(24'h040000 + $urandom_range(0, 24'h3ffff))
                           : AttrW'($urandom);
    endcase
  endfunction

  task automatic send_beat(op_e op, logic [AttrW-1:0] at [NAttr], logic [2:0] lab,
                           bit gap = 1'b1);
    logic [InW-1:0] d;
    int w;
    w = gap ? $urandom_range(0, 8) : 0;
    if (w != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (w) @(negedge clk_i);
    end
    d = '0;
    for (int a = 0; a < NAttr; a++) d[a*AttrW +: AttrW] = at[a];
    d[218:216] = lab;
    s_axis_tdata  = d;
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    if (op == OP_LOAD) n_loads++;
    if (op == OP_QUERY) n_queries++;
  endtask

  task automatic rand_beat(op_e op, bit near, logic [2:0] lab);
    logic [AttrW-1:0] at [NAttr];
    for (int a = 0; a < NAttr; a++) at[a] = rand_attr(near);
    send_beat(op, at, lab, $urandom_range(0, 4) != 0);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [AttrW-1:0] z [NAttr], f [NAttr];
    int k;
    for (int a = 0; a < NAttr; a++) begin
      z[a] = '0;
      f[a] = '1;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: empty store, extremes, ignored beats, ties
    send_beat(OP_QUERY, z, 3'd0);
    send_beat(OP_LOAD, z, 3'd0);
    send_beat(OP_LOAD, f, 3'd0);
    send_beat(OP_NONE, f, 3'd7);
    send_beat(OP_QUERY, f, 3'd7);
    send_beat(OP_LOAD, z, 3'd1);
    send_beat(OP_LOAD, f, 3'd7);
    send_beat(OP_QUERY, z, 3'd5);
    send_beat(OP_QUERY, f, 3'd0);
    send_beat(OP_LOAD, f, 3'd3);
    send_beat(OP_LOAD, z, 3'd2);
    send_beat(OP_QUERY, z, 3'd0);
    send_beat(OP_QUERY, f, 3'd0);
    for (int a = 0; a < NAttr; a++) f[a] = 24'h800000;
    send_beat(OP_QUERY, f, 3'd0);
    send_beat(OP_CLEAR, f, 3'd6);
    send_beat(OP_QUERY, z, 3'd1);
    drain();
    // pressure: receiver stalls while queries keep coming
    send_beat(OP_CLEAR, z, 3'd0);
    for (int i = 0; i < 3; i++) rand_beat(OP_LOAD, 1'b1, 3'($urandom_range(1, 7)));
    hold_off = 1'b1;
    for (int i = 0; i < 4; i++) rand_beat(OP_QUERY, 1'b1, 3'($urandom));
    drain();
    // random: small stores, mostly loads and queries, some noise
    for (int i = 0; i < 75; i++) begin
      k = $urandom_range(0, 19);
      if (k == 0) send_beat(OP_CLEAR, z, 3'($urandom));
      else if (k == 1) rand_beat(OP_NONE, 1'b0, 3'($urandom));
      else if (k == 2) rand_beat(OP_LOAD, 1'b0, 3'd0);
      else if (k < 12) rand_beat(OP_LOAD, 1'b1, 3'($urandom_range(1, 7)));
      else rand_beat(OP_QUERY, k < 17, 3'($urandom));
      if (board.count > 40) send_beat(OP_CLEAR, z, 3'd0);
    end
    drain();
    repeat (50) @(negedge clk_i);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("covered %0d loads and %0d queries, incl. empty stores, ties and stalls",
             n_loads, n_queries);
    $display("%0d results checked", board.n_checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/mdc_pkg.sv
rtl/mean_distance_classifier_unit.sv
tb/testbench.sv
